@@ hdl/hrbm_pkg.sv @@
// shared types, constants and status codes for the history ring with busy marks
// no dependencies; used by hrbm_ctrl, hrbm_dp and the top level
`default_nettype none

package hrbm_pkg;

  // default number of slots the ring hardware holds
  localparam int SLOT_COUNT_DEF = 16;

  // element width kept from put_data
  localparam int ELEMENT_BITS = 32;

  // field widths
  localparam int RING_W   = 5;
  localparam int SLOT_W   = 4;
  localparam int DATA_W   = 32;
  localparam int SEQ_W    = 32;
  localparam int STATUS_W = 2;

  // mask that keeps the low element bits of put_data
  localparam logic [DATA_W-1:0] ELEM_MASK = (ELEMENT_BITS >= DATA_W) ? {DATA_W{1'b1}} :
    DATA_W'((64'd1 << ELEMENT_BITS) - 64'd1);

  // reset value of the ring size register
  localparam logic [RING_W-1:0] RING_RESET = RING_W'(16);

  // input action codes
  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_DONE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BLOCKED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture the input item
    logic exec;  // apply the captured item and register its result
  } ctl_cmd_t;

endpackage

`default_nettype wire

@@ hdl/hrbm_ctrl.sv @@
// controller state machine: sequences capture and execute of one item
// depends on hrbm_pkg (ctl_cmd_t)
`default_nettype none

module hrbm_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  output hrbm_pkg::ctl_cmd_t  cmd,
  output logic                out_valid
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;
  logic out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.exec;
    end
  end

  assign busy      = (state_r == S_EXEC);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ hdl/hrbm_dp.sv @@
// datapath: ring pointers, sequence counter, busy marks, ring size register and result regs
// depends on hrbm_pkg (widths, codes, ctl_cmd_t)
`default_nettype none

module hrbm_dp #(
  parameter int SLOT_COUNT = hrbm_pkg::SLOT_COUNT_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  hrbm_pkg::ctl_cmd_t                  cmd,
  input  wire                                 cfg_we,
  input  wire [hrbm_pkg::RING_W-1:0]          cfg_data,
  input  wire                                 in_action,
  input  wire [hrbm_pkg::DATA_W-1:0]          in_put_data,
  input  wire [hrbm_pkg::SLOT_W-1:0]          in_done_slot,
  output logic [hrbm_pkg::STATUS_W-1:0]       out_status,
  output logic [hrbm_pkg::SLOT_W-1:0]         out_slot,
  output logic [hrbm_pkg::SEQ_W-1:0]          out_sequence_res,
  output logic [hrbm_pkg::DATA_W-1:0]         out_dispatch_data
);

  // only slots below 31 can ever be reached by the ring size register
  localparam int MARK_COUNT = (SLOT_COUNT < 32) ? SLOT_COUNT : 32;
  localparam int CAP_N      = (SLOT_COUNT < 31) ? SLOT_COUNT : 31;
  localparam int PTR_W      = $clog2(MARK_COUNT);
  localparam int INC_W      = hrbm_pkg::RING_W + 1;

  logic [hrbm_pkg::RING_W-1:0]   ring_slots_r;
  logic [PTR_W-1:0]              head_r;
  logic [PTR_W-1:0]              tail_r;
  logic [hrbm_pkg::SEQ_W-1:0]    seq_r;
  logic [MARK_COUNT-1:0]         busy_r;
  logic [MARK_COUNT-1:0]         busy_nxt;

  // captured input item
  logic                          act_r;
  logic [hrbm_pkg::DATA_W-1:0]   data_r;
  logic [hrbm_pkg::SLOT_W-1:0]   done_r;

  // result registers
  logic [hrbm_pkg::STATUS_W-1:0] status_r;
  logic [hrbm_pkg::SLOT_W-1:0]   slot_r;
  logic [hrbm_pkg::SEQ_W-1:0]    seqres_r;
  logic [hrbm_pkg::DATA_W-1:0]   disp_r;

  logic [hrbm_pkg::RING_W-1:0]   n_eff;
  logic [INC_W-1:0]              head_inc;
  logic [INC_W-1:0]              tail_inc;
  logic [PTR_W-1:0]              next_slot;
  logic [PTR_W-1:0]              tail_succ;
  logic                          blocked;
  logic                          put_ok;
  logic                          done_hit;

  // slots in use: zero acts as one, clamp to the ring hardware
  always_comb begin
    if (ring_slots_r == '0) begin
      n_eff = hrbm_pkg::RING_W'(1);
    end else if (ring_slots_r > hrbm_pkg::RING_W'(CAP_N)) begin
      n_eff = hrbm_pkg::RING_W'(CAP_N);
    end else begin
      n_eff = ring_slots_r;
    end
  end

  // successors of head and tail, wrapping at the slots in use
  assign head_inc  = INC_W'(head_r) + INC_W'(1);
  assign tail_inc  = INC_W'(tail_r) + INC_W'(1);
  assign next_slot = (head_inc >= INC_W'(n_eff)) ? '0 : PTR_W'(head_inc);
  assign tail_succ = (tail_inc >= INC_W'(n_eff)) ? '0 : PTR_W'(tail_inc);

  // put refused when the next slot is the busy tail
  assign blocked  = (next_slot == tail_r) && busy_r[next_slot];
  assign put_ok   = cmd.exec && (act_r == hrbm_pkg::ACT_PUT) && !blocked;
  assign done_hit = cmd.exec && (act_r == hrbm_pkg::ACT_DONE);

  // busy mark updates, one compare per slot
  always_comb begin
    for (int i = 0; i < MARK_COUNT; i++) begin
      busy_nxt[i] = busy_r[i];
      if (done_hit && (INC_W'(done_r) == INC_W'(i))) begin
        busy_nxt[i] = 1'b0;
      end
      if (put_ok && (next_slot == PTR_W'(i))) begin
        busy_nxt[i] = 1'b1;
      end
    end
  end

  // control state: ring size, pointers, sequence, busy marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_slots_r <= hrbm_pkg::RING_RESET;
      head_r       <= '0;
      tail_r       <= '0;
      seq_r        <= hrbm_pkg::SEQ_W'(1);
      busy_r       <= '0;
    end else begin
      if (cfg_we) begin
        ring_slots_r <= cfg_data;
      end
      busy_r <= busy_nxt;
      if (put_ok) begin
        head_r <= next_slot;
        seq_r  <= seq_r + hrbm_pkg::SEQ_W'(1);
        if (next_slot == tail_r) begin
          tail_r <= tail_succ;
        end
      end
    end
  end

  // input capture on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      data_r <= in_put_data & hrbm_pkg::ELEM_MASK;
      done_r <= in_done_slot;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (act_r == hrbm_pkg::ACT_DONE) begin
        status_r <= hrbm_pkg::ST_DONE;
        slot_r   <= done_r;
        seqres_r <= '0;
        disp_r   <= '0;
      end else if (blocked) begin
        status_r <= hrbm_pkg::ST_BLOCKED;
        slot_r   <= hrbm_pkg::SLOT_W'(next_slot);
        seqres_r <= '0;
        disp_r   <= '0;
      end else begin
        status_r <= hrbm_pkg::ST_ACCEPTED;
        slot_r   <= hrbm_pkg::SLOT_W'(next_slot);
        seqres_r <= seq_r;
        disp_r   <= data_r;
      end
    end
  end

  assign out_status        = status_r;
  assign out_slot          = slot_r;
  assign out_sequence_res  = seqres_r;
  assign out_dispatch_data = disp_r;

endmodule

`default_nettype wire

@@ hdl/history_ring_with_busy_marks_top.sv @@
// top level of the history ring with busy marks: controller plus datapath
// depends on hrbm_pkg, hrbm_ctrl, hrbm_dp
//
//  channel   handshake            payload
//  input     start / busy         in_action, in_put_data, in_done_slot
//  result    out_valid (strobe)   out_status, out_slot, out_sequence_res, out_dispatch_data
//  config    cfg_valid/cfg_ready  cfg_data (ring size)
//
// an item is captured at its transfer, then applied in the pointer and busy mark update
// its result strobes for one cycle after that, while the next item may already transfer
// busy is high during the update cycle; the config port is ready whenever busy is low
// synchronous active-low reset: head and tail 0, sequence 1, marks clear, ring size 16
// results cannot be stalled; each is shown for exactly one cycle
`default_nettype none

module history_ring_with_busy_marks_top #(
  parameter int SLOT_COUNT = hrbm_pkg::SLOT_COUNT_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  output logic                                busy,
  input  wire                                 in_action,
  input  wire [hrbm_pkg::DATA_W-1:0]          in_put_data,
  input  wire [hrbm_pkg::SLOT_W-1:0]          in_done_slot,
  output logic                                out_valid,
  output logic [hrbm_pkg::STATUS_W-1:0]       out_status,
  output logic [hrbm_pkg::SLOT_W-1:0]         out_slot,
  output logic [hrbm_pkg::SEQ_W-1:0]          out_sequence_res,
  output logic [hrbm_pkg::DATA_W-1:0]         out_dispatch_data,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [hrbm_pkg::RING_W-1:0]          cfg_data
);

  hrbm_pkg::ctl_cmd_t cmd;
  logic               cfg_we;

  // config transfer while no update is in flight
  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  hrbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  hrbm_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .in_action         (in_action),
    .in_put_data       (in_put_data),
    .in_done_slot      (in_done_slot),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_sequence_res  (out_sequence_res),
    .out_dispatch_data (out_dispatch_data)
  );

  // a transfer always leads to the update cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not enter update");

  // the update cycle is always followed by a result strobe
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("update without result");

  // every result follows a transfer and its update cycle
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without transfer");

  // results carry only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == hrbm_pkg::ST_ACCEPTED ||
                   out_status == hrbm_pkg::ST_BLOCKED ||
                   out_status == hrbm_pkg::ST_DONE))
    else $error("undefined status code");

endmodule

`default_nettype wire

@@ dv/hrbm_ring_checker.sv @@
// checker for the history ring with busy marks: predicts every result and compares it
// depends on hrbm_pkg; watches the input, result and config channels of the top level
`default_nettype none

module hrbm_ring_checker #(
  parameter int SLOT_COUNT = hrbm_pkg::SLOT_COUNT_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire                           busy,
  input  wire                           in_action,
  input  wire [hrbm_pkg::DATA_W-1:0]    in_put_data,
  input  wire [hrbm_pkg::SLOT_W-1:0]    in_done_slot,
  input  wire                           out_valid,
  input  wire [hrbm_pkg::STATUS_W-1:0]  out_status,
  input  wire [hrbm_pkg::SLOT_W-1:0]    out_slot,
  input  wire [hrbm_pkg::SEQ_W-1:0]     out_sequence_res,
  input  wire [hrbm_pkg::DATA_W-1:0]    out_dispatch_data,
  input  wire                           cfg_valid,
  input  wire                           cfg_ready,
  input  wire [hrbm_pkg::RING_W-1:0]    cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import hrbm_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [SEQ_W-1:0]    seq;
    logic [DATA_W-1:0]   data;
  } ring_result_t;

  // predicted ring state
  ring_result_t      awaited_results[$];
  logic [RING_W-1:0] ring_size;
  logic [SLOT_W-1:0] head_ptr;
  logic [SLOT_W-1:0] tail_ptr;
  logic [SEQ_W-1:0]  seq_next;
  logic              busy_mark [SLOT_COUNT];
  int                failures = 0;
  int                outstanding = 0;

  assign fail_count = failures;
  assign pending    = outstanding;

  // size 0 behaves as one slot, oversize clamps to the hardware slot count
  function automatic int live_slots();
    if (ring_size == 0) return 1;
    if (ring_size > SLOT_COUNT) return SLOT_COUNT;
    return int'(ring_size);
  endfunction

  // pointers at or past the last slot in use wrap to slot 0
  function automatic int after_slot(int p);
    return (p + 1 >= live_slots()) ? 0 : p + 1;
  endfunction

  // apply one item to the predicted state and return its result
  function automatic ring_result_t apply_item(logic act, logic [DATA_W-1:0] data,
                                              logic [SLOT_W-1:0] dslot);
    ring_result_t r;
    int           nxt;
    r = '0;
    if (act == ACT_DONE) begin
      if (dslot < SLOT_COUNT) busy_mark[dslot] = 1'b0;
      r.status = ST_DONE;
      r.slot   = dslot;
      return r;
    end
    nxt = after_slot(int'(head_ptr));
    // refuse the put while the oldest entry still has a handler running
    if (nxt == tail_ptr && nxt < SLOT_COUNT && busy_mark[nxt]) begin
      r.status = ST_BLOCKED;
      r.slot   = SLOT_W'(nxt);
      return r;
    end
    if (nxt < SLOT_COUNT) busy_mark[nxt] = 1'b1;
    head_ptr = SLOT_W'(nxt);
    if (nxt == tail_ptr) tail_ptr = SLOT_W'(after_slot(int'(tail_ptr)));
    r.status = ST_ACCEPTED;
    r.slot   = SLOT_W'(nxt);
    r.seq    = seq_next;
    r.data   = data & ELEM_MASK;
    seq_next = seq_next + 1'b1;
    return r;
  endfunction

  // watch transfers at each rising edge
  always @(posedge clk) begin
    ring_result_t want;
    ring_result_t got;
    if (!rst_n) begin
      ring_size = RING_RESET;
      head_ptr  = '0;
      tail_ptr  = '0;
      seq_next  = SEQ_W'(1);
      for (int i = 0; i < SLOT_COUNT; i++) busy_mark[i] = 1'b0;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) ring_size = cfg_data;
      // result strobe belongs to the oldest outstanding item
      if (out_valid) begin
        got = '{out_status, out_slot, out_sequence_res, out_dispatch_data};
        if (awaited_results.size() == 0) begin
          if (failures < 10)
            $display("[%0t] result with nothing outstanding: status %0d slot %0d seq %0h data %0h",
                     $realtime, got.status, got.slot, got.seq, got.data);
          failures++;
        end else begin
          want = awaited_results.pop_front();
          if (got.status != want.status || got.slot != want.slot ||
              got.seq != want.seq || got.data != want.data) begin
            if (failures < 10)
              $display({"[%0t] mismatch: status exp %0d got %0d, slot exp %0d got %0d, ",
                        "seq exp %0h got %0h, data exp %0h got %0h"},
                       $realtime, want.status, got.status, want.slot, got.slot,
                       want.seq, got.seq, want.data, got.data);
            failures++;
          end
        end
      end
      if (start && !busy)
        awaited_results.push_back(apply_item(in_action, in_put_data, in_done_slot));
    end
    outstanding = awaited_results.size();
  end

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// testbench top for history_ring_with_busy_marks_top: clock, reset, stimulus and verdict
// depends on hrbm_pkg, the block and hrbm_ring_checker in this folder
`default_nettype none

module testbench;
  import hrbm_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 100;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                in_action;
  logic [DATA_W-1:0]   in_put_data;
  logic [SLOT_W-1:0]   in_done_slot;
  logic                cfg_valid;
  logic [RING_W-1:0]   cfg_data;
  wire                 busy;
  wire                 out_valid;
  wire [STATUS_W-1:0]  out_status;
  wire [SLOT_W-1:0]    out_slot;
  wire [SEQ_W-1:0]     out_sequence_res;
  wire [DATA_W-1:0]    out_dispatch_data;
  wire                 cfg_ready;
  int                  fail_count;
  int                  pending;

  logic [RING_W-1:0]   ring_setting;
  logic [RING_W-1:0]   ring_plan [PHASES];
  int                  put_pct;
  bit                  idle_on;
  int                  stall_cycles = 0;

  history_ring_with_busy_marks_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_put_data       (in_put_data),
    .in_done_slot      (in_done_slot),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_sequence_res  (out_sequence_res),
    .out_dispatch_data (out_dispatch_data),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  hrbm_ring_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_put_data       (in_put_data),
    .in_done_slot      (in_done_slot),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_sequence_res  (out_sequence_res),
    .out_dispatch_data (out_dispatch_data),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: end the run after too many cycles without any transfer
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("FAIL history_ring_with_busy_marks_top");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // random burst of idle cycles with noise on the payload
  task automatic idle_gap();
    int n;
    n = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
    repeat (n) begin
      @(negedge clk);
      start        = 1'b0;
      in_action    = 1'($urandom_range(0, 1));
      in_put_data  = $urandom();
      in_done_slot = SLOT_W'($urandom_range(0, 15));
    end
  endtask

  // present one item and hold it until the block takes it
  task automatic issue(logic act, logic [DATA_W-1:0] data, logic [SLOT_W-1:0] dslot);
    idle_gap();
    @(negedge clk);
    start        = 1'b1;
    in_action    = act;
    in_put_data  = data;
    in_done_slot = dslot;
    do @(posedge clk); while (busy);
  endtask

  // stop sending until every outstanding result has come back
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // ring size write, only with the block idle
  task automatic write_ring(logic [RING_W-1:0] v);
    drain();
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid    = 1'b0;
    ring_setting = v;
  endtask

  // random put or completion, completions mostly aimed at slots in use
  task automatic random_item();
    int                live;
    logic [DATA_W-1:0] d;
    logic [SLOT_W-1:0] s;
    live = (ring_setting == 0) ? 1 :
           (ring_setting > SLOT_COUNT_DEF) ? SLOT_COUNT_DEF : int'(ring_setting);
    case ($urandom_range(0, 9))
      0:       d = '0;
      1:       d = '1;
      default: d = $urandom();
    endcase
    s = ($urandom_range(0, 4) == 0) ? SLOT_W'($urandom_range(0, 15)) :
                                      SLOT_W'($urandom_range(0, live - 1));
    issue(($urandom_range(0, 99) < put_pct) ? ACT_PUT : ACT_DONE, d, s);
  endtask

  initial begin
    start        = 1'b0;
    in_action    = ACT_PUT;
    in_put_data  = '0;
    in_done_slot = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    rst_n        = 1'b0;
    idle_on      = 1'b1;
    put_pct      = 55;
    ring_setting = RING_RESET;
    ring_plan    = '{5'd3, 5'd31, 5'd1, 5'd16, 5'd0, 5'd2, 5'd7, 5'd5};
    ring_plan[6] = RING_W'($urandom_range(2, 15));
    ring_plan[7] = RING_W'($urandom_range(17, 31));
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // data extremes and completions on used, unused and idle slots
    issue(ACT_PUT, '0, '0);
    issue(ACT_PUT, '1, 4'd15);
    issue(ACT_DONE, '1, 4'd1);
    issue(ACT_DONE, '0, 4'd15);
    issue(ACT_DONE, '0, 4'd15);
    issue(ACT_PUT, 32'hA5A5_A5A5, '0);
    issue(ACT_DONE, '0, '0);

    // shrink below head, fill up and hit a busy tail
    write_ring(5'd2);
    issue(ACT_PUT, 32'h0000_0001, '0);
    issue(ACT_PUT, 32'h0000_0002, '0);
    issue(ACT_PUT, 32'h0000_0003, '0);
    issue(ACT_DONE, '0, '0);
    issue(ACT_PUT, 32'h0000_0004, '0);

    // zero size behaves as a single slot
    write_ring(5'd0);
    issue(ACT_PUT, 32'h0000_0005, '0);
    issue(ACT_PUT, 32'h0000_0006, '0);
    issue(ACT_DONE, '0, '0);
    issue(ACT_PUT, 32'h0000_0007, '0);

    // oversize clamps to the slot count
    write_ring(5'd31);
    issue(ACT_PUT, 32'h5A5A_5A5A, '0);
    issue(ACT_PUT, 32'h1234_5678, '0);
    issue(ACT_PUT, 32'h8000_0001, '0);
    issue(ACT_DONE, '0, 4'd3);

    write_ring(5'd1);
    issue(ACT_PUT, 32'h7FFF_FFFE, '0);
    issue(ACT_PUT, 32'hFFFF_0000, '0);
    issue(ACT_DONE, '0, '0);

    // random phases, one ring size each; phase 3 and the last one without idling
    for (int ph = 0; ph < PHASES; ph++) begin
      write_ring(ring_plan[ph]);
      idle_on = (ph != 3 && ph != PHASES - 1);
      put_pct = (ring_plan[ph] > 5'd8) ? 70 : 55;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 59) == 0) drain();
        random_item();
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("PASS history_ring_with_busy_marks_top");
    end else begin
      $display("FAIL history_ring_with_busy_marks_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
